### design/tpq_pkg.sv
// Shared types and constants of the three-level priority queue.
// No dependencies; every other file but tpq_ram imports this package.
package tpq_pkg;

  localparam int unsigned LEVEL_DEPTH_DEF = 16;
  localparam int unsigned TAG_BITS_DEF    = 16;

  localparam int unsigned TAG_W = 16;
  localparam int unsigned URG_W = 2;
  localparam int unsigned ST_W  = 3;

  typedef enum logic {
    OP_ENQ = 1'b0,
    OP_DEQ = 1'b1
  } op_e;

  typedef enum logic [ST_W-1:0] {
    ST_ENQUEUED = 3'd0,
    ST_DEQUEUED = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_INVALID  = 3'd3,
    ST_FULL     = 3'd4
  } status_e;

  // Urgency codes
  localparam logic [URG_W-1:0] URG_NONE = 2'd0;
  localparam logic [URG_W-1:0] URG_HIGH = 2'd1;
  localparam logic [URG_W-1:0] URG_MID  = 2'd2;
  localparam logic [URG_W-1:0] URG_LOW  = 2'd3;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_READ = 1'b1
  } state_e;

  // Decision of the bookkeeping unit for one transaction
  typedef struct packed {
    logic             wr;
    logic             rd;
    status_e          status;
    logic [URG_W-1:0] lvl;
  } tpq_op_t;

endpackage

### design/tpq_if.sv
// Request and response channel interfaces of the priority queue.
// Depends on tpq_pkg.
interface tpq_req_if import tpq_pkg::*; ();
  logic             valid;
  logic             ready;
  op_e              opcode;
  logic [TAG_W-1:0] patient_tag;
  logic [URG_W-1:0] urgency;

  modport source(output valid, opcode, patient_tag, urgency, input ready);
  modport sink(input valid, opcode, patient_tag, urgency, output ready);
endinterface

interface tpq_rsp_if import tpq_pkg::*; ();
  logic             valid;
  logic             ready;
  status_e          status;
  logic [TAG_W-1:0] served_tag;
  logic [URG_W-1:0] served_urgency;

  modport source(output valid, status, served_tag, served_urgency, input ready);
  modport sink(input valid, status, served_tag, served_urgency, output ready);
endinterface

### design/tpq_ram.sv
// Generic single-clock RAM, one write and one read port, registered read.
// No dependencies.
module tpq_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### design/tpq_ctrl.sv
// Pointer and fill-count bookkeeping: decides each transaction and forms
// the tag memory address. Depends on tpq_pkg.
module tpq_ctrl import tpq_pkg::*; #(
  parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  localparam int unsigned PW = $clog2(LEVEL_DEPTH),
  localparam int unsigned CW = $clog2(LEVEL_DEPTH + 1),
  localparam int unsigned AW = $clog2(3 * LEVEL_DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             acc_i,
  input  op_e              opcode_i,
  input  logic [URG_W-1:0] urgency_i,
  output tpq_op_t          op_o,
  output logic [AW-1:0]    addr_o
);

  localparam logic [CW-1:0] CntFull = CW'(LEVEL_DEPTH);
  localparam logic [PW-1:0] PtrLast = PW'(LEVEL_DEPTH - 1);

  logic [CW-1:0] cnt_q  [3];
  logic [CW-1:0] cnt_d  [3];
  logic [PW-1:0] head_q [2];
  logic [PW-1:0] head_d [2];
  logic [PW-1:0] tail_q [2];
  logic [PW-1:0] tail_d [2];

  logic [1:0]    lv;
  logic          f;
  logic [CW-1:0] top_m1;

  function automatic logic [AW-1:0] slot(input logic [1:0] l, input logic [PW-1:0] p);
    logic [AW-1:0] base;
    case (l)
      2'd1:    base = AW'(LEVEL_DEPTH);
      2'd2:    base = AW'(2 * LEVEL_DEPTH);
      default: base = '0;
    endcase
    return base + AW'(p);
  endfunction

  function automatic logic [PW-1:0] ptr_next(input logic [PW-1:0] p);
    return (p == PtrLast) ? '0 : p + 1'b1;
  endfunction

  always_comb begin
    op_o   = '{wr: 1'b0, rd: 1'b0, status: ST_EMPTY, lvl: URG_NONE};
    addr_o = '0;
    cnt_d  = cnt_q;
    head_d = head_q;
    tail_d = tail_q;
    lv     = urgency_i - 1'b1;
    f      = 1'b0;
    top_m1 = cnt_q[0] - 1'b1;
    if (opcode_i == OP_ENQ) begin
      if (urgency_i == URG_NONE) begin
        op_o.status = ST_INVALID;
      end else if (cnt_q[lv] == CntFull) begin
        op_o.status = ST_FULL;
      end else begin
        op_o.status = ST_ENQUEUED;
        op_o.wr     = 1'b1;
        cnt_d[lv]   = cnt_q[lv] + 1'b1;
        if (lv == 2'd0) begin
          // level 1 is a stack, top at count - 1
          addr_o = slot(2'd0, cnt_q[0][PW-1:0]);
        end else begin
          f         = lv[1];
          addr_o    = slot(lv, tail_q[f]);
          tail_d[f] = ptr_next(tail_q[f]);
        end
      end
    end else begin
      if (cnt_q[0] != '0) begin
        op_o.status = ST_DEQUEUED;
        op_o.rd     = 1'b1;
        op_o.lvl    = URG_HIGH;
        cnt_d[0]    = top_m1;
        addr_o      = slot(2'd0, top_m1[PW-1:0]);
      end else if (cnt_q[1] != '0 || cnt_q[2] != '0) begin
        f            = (cnt_q[1] == '0);
        op_o.status  = ST_DEQUEUED;
        op_o.rd      = 1'b1;
        op_o.lvl     = f ? URG_LOW : URG_MID;
        addr_o       = slot({f, ~f}, head_q[f]);
        cnt_d[{f, ~f}] = cnt_q[{f, ~f}] - 1'b1;
        if (cnt_q[{f, ~f}] == CW'(1)) begin
          // level drained: pointers back to the start
          head_d[f] = '0;
          tail_d[f] = '0;
        end else begin
          head_d[f] = ptr_next(head_q[f]);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '{default: '0};
      head_q <= '{default: '0};
      tail_q <= '{default: '0};
    end else if (acc_i) begin
      cnt_q  <= cnt_d;
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

endmodule

### design/three_level_priority_queue.sv
// Three-level strict priority queue. Enqueue, invalid, full and empty
// transactions give their result in the cycle after acceptance; a dequeue gives
// it through the registered read of the tag memory and then the output register.
// Throughput: one transaction a cycle; a dequeue holds the input off while the
// tag memory is read, and a request is taken only when the output register is empty or
// being emptied. Reset clears all counts and pointers; the tag memory is not
// cleared and needs no clearing pass.
// Depends on tpq_pkg, tpq_if, tpq_ram and tpq_ctrl.
module three_level_priority_queue import tpq_pkg::*; #(
  parameter int unsigned LEVEL_DEPTH = LEVEL_DEPTH_DEF,
  parameter int unsigned TAG_BITS    = TAG_BITS_DEF
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  tpq_req_if.sink req_i,
  tpq_rsp_if.source rsp_o
);

  localparam int unsigned SW    = (TAG_BITS < TAG_W) ? TAG_BITS : TAG_W;
  localparam int unsigned DEPTH = 3 * LEVEL_DEPTH;
  localparam int unsigned AW    = $clog2(DEPTH);

  state_e           state_q, state_d;
  tpq_op_t          op;
  logic [AW-1:0]    addr;
  logic [SW-1:0]    rdata;
  logic             acc;
  logic             out_free;
  logic             ld_now;
  logic             ld_mem;
  logic [URG_W-1:0] lvl_q;

  logic             out_valid_q, out_valid_d;
  status_e          out_status_q, out_status_d;
  logic [TAG_W-1:0] out_tag_q, out_tag_d;
  logic [URG_W-1:0] out_urg_q, out_urg_d;

  assign out_free = !out_valid_q || rsp_o.ready;
  assign acc      = req_i.valid && req_i.ready;

  tpq_ctrl #(
    .LEVEL_DEPTH(LEVEL_DEPTH)
  ) u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .acc_i    (acc),
    .opcode_i (req_i.opcode),
    .urgency_i(req_i.urgency),
    .op_o     (op),
    .addr_o   (addr)
  );

  tpq_ram #(
    .WIDTH(SW),
    .DEPTH(DEPTH)
  ) u_tag_ram (
    .clk_i  (clk_i),
    .we_i   (acc && op.wr),
    .waddr_i(addr),
    .wdata_i(SW'(req_i.patient_tag)),
    .re_i   (acc && op.rd),
    .raddr_i(addr),
    .rdata_o(rdata)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (acc && op.rd) begin
          state_d = S_READ;
        end
      end
      S_READ: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // outputs of the state machine
  always_comb begin
    req_i.ready = 1'b0;
    ld_now      = 1'b0;
    ld_mem      = 1'b0;
    case (state_q)
      S_IDLE: begin
        req_i.ready = out_free;
        ld_now      = acc && !op.rd;
      end
      S_READ: begin
        ld_mem = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d  = out_valid_q;
    out_status_d = out_status_q;
    out_tag_d    = out_tag_q;
    out_urg_d    = out_urg_q;
    if (ld_now) begin
      out_valid_d  = 1'b1;
      out_status_d = op.status;
      out_tag_d    = '0;
      out_urg_d    = URG_NONE;
    end else if (ld_mem) begin
      out_valid_d  = 1'b1;
      out_status_d = ST_DEQUEUED;
      out_tag_d    = TAG_W'(rdata);
      out_urg_d    = lvl_q;
    end else if (rsp_o.ready) begin
      out_valid_d  = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_status_q <= out_status_d;
    out_tag_q    <= out_tag_d;
    out_urg_q    <= out_urg_d;
    if (acc && op.rd) begin
      lvl_q <= op.lvl;
    end
  end

  assign rsp_o.valid          = out_valid_q;
  assign rsp_o.status         = out_status_q;
  assign rsp_o.served_tag     = out_tag_q;
  assign rsp_o.served_urgency = out_urg_q;

  a_deq_reads: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && op.rd) |=> (state_q == S_READ && !req_i.ready))
    else $error("dequeue did not enter the memory read state");

  a_rise_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(rsp_o.valid) |-> ($past(acc) || $past(state_q == S_READ)))
    else $error("response appeared without a transaction");

  a_urg_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> ((rsp_o.status == ST_DEQUEUED) == (rsp_o.served_urgency != URG_NONE)))
    else $error("served urgency disagrees with status");

endmodule

### sim/tb.sv
// Self-checking testbench of three_level_priority_queue: a queue-filled driver and a
// checking monitor, with random gaps on both channels and a local predictor.
// Depends on tpq_pkg, tpq_if and the design files.
module tb;
  import tpq_pkg::*;

  localparam int DEPTH = LEVEL_DEPTH_DEF;
  localparam int N_RANDOM = 1000;

  typedef struct {
    op_e              op;
    logic [TAG_W-1:0] tag;
    logic [URG_W-1:0] urg;
    bit               drain;  // hold back until every response is in
  } req_item_t;

  typedef struct {
    status_e          status;
    logic [TAG_W-1:0] tag;
    logic [URG_W-1:0] urg;
  } rsp_item_t;

  logic clk;
  logic rst_n;

  tpq_req_if req_if ();
  tpq_rsp_if rsp_if ();

  three_level_priority_queue u_top (
    .clk_i (clk),
    .rst_ni(rst_n),
    .req_i (req_if),
    .rsp_o (rsp_if)
  );

  req_item_t pending_reqs[$];
  rsp_item_t awaited_rsps[$];
  int        fail_cnt = 0;

  // Predictor state: level 1 is a stack, levels 2 and 3 are ring buffers
  logic [TAG_W-1:0] level_mem [3][DEPTH];
  int               level_cnt [3];
  int               rd_ptr    [2];
  int               wr_ptr    [2];

  function automatic rsp_item_t predict_queue(op_e op, logic [TAG_W-1:0] tag,
                                              logic [URG_W-1:0] urg);
    rsp_item_t r;
    int        lv;
    int        f;
    r.status = ST_EMPTY;
    r.tag    = '0;
    r.urg    = URG_NONE;
    if (op == OP_ENQ) begin
      if (urg == URG_NONE) begin
        r.status = ST_INVALID;
      end else begin
        lv = int'(urg) - 1;
        if (level_cnt[lv] >= DEPTH) begin
          r.status = ST_FULL;
        end else if (lv == 0) begin
          level_mem[0][level_cnt[0]] = tag;
          level_cnt[0]++;
          r.status = ST_ENQUEUED;
        end else begin
          f = lv - 1;
          level_mem[lv][wr_ptr[f]] = tag;
          wr_ptr[f] = (wr_ptr[f] + 1 >= DEPTH) ? 0 : wr_ptr[f] + 1;
          level_cnt[lv]++;
          r.status = ST_ENQUEUED;
        end
      end
    end else if (level_cnt[0] != 0) begin
      level_cnt[0]--;
      r.tag    = level_mem[0][level_cnt[0]];
      r.urg    = URG_HIGH;
      r.status = ST_DEQUEUED;
    end else if (level_cnt[1] != 0 || level_cnt[2] != 0) begin
      lv = (level_cnt[1] != 0) ? 1 : 2;
      f  = lv - 1;
      r.tag    = level_mem[lv][rd_ptr[f]];
      r.urg    = (lv == 1) ? URG_MID : URG_LOW;
      r.status = ST_DEQUEUED;
      rd_ptr[f] = (rd_ptr[f] + 1 >= DEPTH) ? 0 : rd_ptr[f] + 1;
      level_cnt[lv]--;
      // drained level restarts at slot zero
      if (level_cnt[lv] == 0) begin
        rd_ptr[f] = 0;
        wr_ptr[f] = 0;
      end
    end
    return r;
  endfunction

  // Mostly short gaps, a few long ones, and now and then a calm stretch
  function automatic int idle_len(inout int calm_left);
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 2) begin
      calm_left = $urandom_range(20, 100);
      return 0;
    end
    if (r < 55) return 0;
    if (r < 88) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  task automatic add_req(op_e op, logic [TAG_W-1:0] tag, logic [URG_W-1:0] urg,
                         bit drain);
    req_item_t it;
    it.op    = op;
    it.tag   = tag;
    it.urg   = urg;
    it.drain = drain;
    pending_reqs.push_back(it);
  endtask

  // Driver
  int        req_gap;
  int        req_calm;
  req_item_t nxt;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      req_if.valid       <= 1'b0;
      req_if.opcode      <= OP_ENQ;
      req_if.patient_tag <= '0;
      req_if.urgency     <= URG_NONE;
      req_gap  = 0;
      req_calm = 0;
      for (int i = 0; i < 3; i++) level_cnt[i] = 0;
      for (int i = 0; i < 2; i++) begin
        rd_ptr[i] = 0;
        wr_ptr[i] = 0;
      end
    end else begin
      if (req_if.valid && req_if.ready)
        awaited_rsps.push_back(predict_queue(req_if.opcode, req_if.patient_tag,
                                             req_if.urgency));
      if (!req_if.valid || req_if.ready) begin
        if (req_gap > 0) begin
          req_gap--;
          req_if.valid <= 1'b0;
        end else if (pending_reqs.size() != 0 &&
                     !(pending_reqs[0].drain && awaited_rsps.size() != 0)) begin
          nxt = pending_reqs.pop_front();
          req_if.valid       <= 1'b1;
          req_if.opcode      <= nxt.op;
          req_if.patient_tag <= nxt.tag;
          req_if.urgency     <= nxt.urg;
          req_gap = idle_len(req_calm);
        end else begin
          req_if.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor
  int        rsp_stall;
  int        rsp_calm;
  rsp_item_t want;

  always @(posedge clk or negedge rst_n) begin
    if (!rst_n) begin
      rsp_if.ready <= 1'b0;
      rsp_stall = 0;
      rsp_calm  = 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (awaited_rsps.size() == 0) begin
          fail_cnt++;
          if (fail_cnt <= 10)
            $display("unexpected response: status %0d tag %h urgency %0d",
                     rsp_if.status, rsp_if.served_tag, rsp_if.served_urgency);
        end else begin
          want = awaited_rsps.pop_front();
          if (rsp_if.status !== want.status || rsp_if.served_tag !== want.tag ||
              rsp_if.served_urgency !== want.urg) begin
            fail_cnt++;
            if (fail_cnt <= 10)
              $display("mismatch: expected status %0d tag %h urgency %0d, got %0d %h %0d",
                       want.status, want.tag, want.urg, rsp_if.status,
                       rsp_if.served_tag, rsp_if.served_urgency);
          end
        end
      end
      if (rsp_stall > 0) begin
        rsp_stall--;
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
        rsp_stall = ($urandom_range(0, 2) == 0) ? idle_len(rsp_calm) : 0;
      end
    end
  end

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #8000000;
    $display("TEST FAILED");
    $finish;
  end

  initial begin
    int          p_enq;
    int          fav;
    logic [URG_W-1:0] u;

    rst_n = 1'b0;

    // Directed: empty queue, invalid priority into empty queue, ordering
    // across levels with extreme tags, drained levels, a full level
    add_req(OP_DEQ, 16'hFFFF, URG_LOW, 1'b0);
    add_req(OP_ENQ, 16'hFFFF, URG_NONE, 1'b0);
    add_req(OP_ENQ, 16'h0000, URG_HIGH, 1'b0);
    add_req(OP_ENQ, 16'hFFFF, URG_MID, 1'b0);
    add_req(OP_ENQ, 16'h5555, URG_LOW, 1'b0);
    add_req(OP_ENQ, 16'hAAAA, URG_HIGH, 1'b0);
    add_req(OP_DEQ, 16'hFFFF, URG_LOW, 1'b0);
    add_req(OP_DEQ, 16'h1234, URG_NONE, 1'b0);
    add_req(OP_DEQ, 16'h0000, URG_MID, 1'b0);
    add_req(OP_DEQ, 16'hFFFF, URG_HIGH, 1'b0);
    add_req(OP_DEQ, 16'h0000, URG_NONE, 1'b0);
    for (int i = 0; i <= DEPTH; i++)
      add_req(OP_ENQ, 16'(i * 16'h0F0F), URG_LOW, 1'b0);

    // Random: blocks with a varying enqueue bias and a favoured level
    p_enq = 50;
    fav   = 1;
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i % 50 == 0) begin
        case ($urandom_range(0, 3))
          0: p_enq = 15;
          1: p_enq = 50;
          2: p_enq = 75;
          default: p_enq = 95;
        endcase
        fav = $urandom_range(1, 3);
      end
      if ($urandom_range(0, 99) < 60) u = URG_W'(fav);
      else if ($urandom_range(0, 19) == 0) u = URG_NONE;
      else u = URG_W'($urandom_range(1, 3));
      add_req(($urandom_range(0, 99) < p_enq) ? OP_ENQ : OP_DEQ,
              TAG_W'($urandom_range(0, 65535)), u,
              (i == 0) || (i % 50 == 0 && $urandom_range(0, 3) == 0));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_reqs.size() != 0 || req_if.valid) @(posedge clk);
    while (awaited_rsps.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);

    if (fail_cnt == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule

### filelist.f
design/tpq_pkg.sv
design/tpq_if.sv
design/tpq_ram.sv
design/tpq_ctrl.sv
design/three_level_priority_queue.sv
sim/tb.sv
